FILE: design/kps_pkg.sv
// Shared types and constants for the keyframe palette sampler.
// Used by the controller, the datapath and the top level; depends on nothing.
package kps_pkg;

    localparam int PALETTE_DEPTH = 65536;
    localparam int CLIP_SLOTS    = 16;
    localparam int WORDS_SHIFT   = 4;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int CLIP_AW       = (CLIP_SLOTS > 1) ? $clog2(CLIP_SLOTS) : 1;
    localparam int IDX_W         = CLIP_AW + 1;
    localparam int CLIP_EW       = 64;
    localparam int DIV_STEPS     = 32;
    localparam int DIV_CW        = $clog2(DIV_STEPS + 1);

    localparam logic CFG_BONES = 1'b0;
    localparam logic CFG_CLIPS = 1'b1;

    typedef enum logic [1:0] {
        ACT_PAL_WRITE  = 2'd0,
        ACT_CLIP_WRITE = 2'd1,
        ACT_SAMPLE     = 2'd2,
        ACT_FIND       = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_SM_CHK,
        S_SM_SEL,
        S_DIV,
        S_DIV_FIX,
        S_ADDR_A,
        S_ADDR_B,
        S_CHK_ADDR,
        S_RD_A,
        S_RD_B,
        S_MUL,
        S_BLEND,
        S_LK_RD,
        S_LK_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic pal_we;
        logic clip_we;
        logic clip_rd_lk;
        logic chk_clip;
        logic set_fault;
        logic div_start;
        logic div_step;
        logic div_fix;
        logic addr_a;
        logic addr_b;
        logic pal_rd_b;
        logic cap_a;
        logic mul;
        logic blend;
        logic lk_hit;
        logic lk_next;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    elem_bad;
        logic    short_clip;
        logic    div_last;
        logic    addr_fault;
        logic    lk_end;
        logic    lk_match;
        logic    out_free;
    } t_sts;

endpackage

FILE: design/kps_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module kps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/kps_ctrl.sv
// Sequencing state machine of the keyframe palette sampler.
// Depends on kps_pkg; drives the datapath by command and reads its status.
module kps_ctrl
    import kps_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_sts   i_sts,
    output logic   o_ready,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DISP;
            end
            S_DISP: begin
                case (i_sts.action)
                    ACT_PAL_WRITE:  n_state = S_DONE;
                    ACT_CLIP_WRITE: n_state = S_DONE;
                    ACT_SAMPLE:     n_state = S_SM_CHK;
                    ACT_FIND:       n_state = S_LK_RD;
                    default:        n_state = S_DONE;
                endcase
            end
            S_SM_CHK: n_state = S_SM_SEL;
            S_SM_SEL: begin
                if (i_sts.elem_bad) n_state = S_DONE;
                else if (i_sts.short_clip) n_state = S_ADDR_A;
                else n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_last) n_state = S_DIV_FIX;
            end
            S_DIV_FIX:  n_state = S_ADDR_A;
            S_ADDR_A:   n_state = S_ADDR_B;
            S_ADDR_B:   n_state = S_CHK_ADDR;
            S_CHK_ADDR: n_state = i_sts.addr_fault ? S_DONE : S_RD_A;
            S_RD_A:     n_state = S_RD_B;
            S_RD_B:     n_state = S_MUL;
            S_MUL:      n_state = S_BLEND;
            S_BLEND:    n_state = S_DONE;
            S_LK_RD:    n_state = i_sts.lk_end ? S_DONE : S_LK_CMP;
            S_LK_CMP:   n_state = i_sts.lk_match ? S_DONE : S_LK_RD;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_DISP: begin
                o_cmd.pal_we  = (i_sts.action == ACT_PAL_WRITE);
                o_cmd.clip_we = (i_sts.action == ACT_CLIP_WRITE);
            end
            S_SM_CHK: o_cmd.chk_clip = 1'b1;
            S_SM_SEL: begin
                o_cmd.set_fault = i_sts.elem_bad;
                o_cmd.div_start = !i_sts.elem_bad && !i_sts.short_clip;
            end
            S_DIV:      o_cmd.div_step = 1'b1;
            S_DIV_FIX:  o_cmd.div_fix = 1'b1;
            S_ADDR_A:   o_cmd.addr_a = 1'b1;
            S_ADDR_B:   o_cmd.addr_b = 1'b1;
            S_CHK_ADDR: o_cmd.set_fault = i_sts.addr_fault;
            S_RD_A:     o_cmd.pal_rd_b = 1'b0;
            S_RD_B: begin
                o_cmd.pal_rd_b = 1'b1;
                o_cmd.cap_a    = 1'b1;
            end
            S_MUL:      o_cmd.mul = 1'b1;
            S_BLEND:    o_cmd.blend = 1'b1;
            S_LK_RD:    o_cmd.clip_rd_lk = 1'b1;
            S_LK_CMP: begin
                o_cmd.clip_rd_lk = 1'b1;
                o_cmd.lk_hit     = i_sts.lk_match;
                o_cmd.lk_next    = !i_sts.lk_match;
            end
            S_DONE:     o_cmd.out_load = i_sts.out_free;
            default:    o_cmd = '0;
        endcase
    end

endmodule

FILE: design/kps_dp.sv
// Datapath of the keyframe palette sampler: memories, divider, blend and result register.
// Depends on kps_pkg and kps_ram; steered by kps_ctrl.
module kps_dp
    import kps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    input  logic [1:0]         i_action,
    input  logic [15:0]        i_word_address,
    input  logic signed [31:0] i_word_value,
    input  logic [3:0]         i_clip_slot,
    input  logic [31:0]        i_clip_key,
    input  logic [15:0]        i_clip_start,
    input  logic [15:0]        i_clip_length,
    input  logic signed [31:0] i_time_in_frames,
    input  logic [11:0]        i_element,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_sample_value,
    output logic               o_fault,
    output logic               o_found,
    output logic [3:0]         o_found_slot
);

    logic [8:0]  r_bones;
    logic [4:0]  r_clips;
    t_action     r_action;
    logic [15:0] r_waddr;
    logic [31:0] r_wval;
    logic [3:0]  r_slot;
    logic [31:0] r_key;
    logic [15:0] r_cstart;
    logic [15:0] r_clen;
    logic [31:0] r_time;
    logic [11:0] r_elem;
    logic [15:0] r_start;
    logic [15:0] r_len;
    logic [31:0] r_rem;
    logic [31:0] r_dvd;
    logic [DIV_CW-1:0] r_div_cnt;
    logic [31:0] r_r;
    logic [30:0] r_pa;
    logic [30:0] r_pb;
    logic [31:0] r_a;
    logic [49:0] r_prod;
    logic [31:0] r_val;
    logic        r_fault;
    logic        r_found;
    logic [IDX_W-1:0] r_idx;
    logic        r_o_valid;
    logic [31:0] r_o_val;
    logic        r_o_fault;
    logic        r_o_found;
    logic [3:0]  r_o_slot;

    logic [12:0]        w_n;
    logic [CLIP_AW-1:0] w_eff_slot;
    logic [CLIP_AW-1:0] w_clip_raddr;
    logic [CLIP_EW-1:0] w_clip_rdata;
    logic [PAL_AW-1:0]  w_pal_raddr;
    logic [31:0]        w_pal_rdata;
    logic               w_pal_bad;
    logic               w_clip_bad;
    logic [31:0]        w_span;
    logic [32:0]        w_rem_sh;
    logic [16:0]        w_f1;
    logic [16:0]        w_fsel;
    logic [29:0]        w_mult;
    logic [30:0]        w_addr;
    logic [31:0]        w_b;
    logic signed [32:0] w_diff;
    logic signed [16:0] w_frac;
    logic signed [49:0] w_prod;

    assign w_n       = {r_bones, 4'b0000};
    assign w_span    = {r_len, 16'h0000};
    assign w_pal_bad = 32'(r_waddr) >= 32'(PALETTE_DEPTH);
    assign w_clip_bad = 32'(r_slot) >= 32'(CLIP_SLOTS);
    assign w_eff_slot = ((32'(r_slot) < 32'(r_clips)) && (32'(r_slot) < 32'(CLIP_SLOTS)))
                        ? CLIP_AW'(r_slot) : '0;
    assign w_clip_raddr = i_cmd.clip_rd_lk ? CLIP_AW'(r_idx) : w_eff_slot;
    assign w_pal_raddr  = i_cmd.pal_rd_b ? PAL_AW'(r_pb) : PAL_AW'(r_pa);

    assign w_rem_sh = {r_rem, r_dvd[31]};
    assign w_f1     = ({1'b0, r_r[31:16]} + 17'd1 == {1'b0, r_len}) ? 17'd0
                      : {1'b0, r_r[31:16]} + 17'd1;
    assign w_fsel   = i_cmd.addr_b ? w_f1 : {1'b0, r_r[31:16]};
    assign w_mult   = ({1'b0, r_start} + w_fsel) * w_n;
    assign w_addr   = 31'(w_mult) + 31'(r_elem);

    assign w_b    = (r_len <= 16'd1) ? r_a : w_pal_rdata;
    assign w_diff = $signed({w_b[31], w_b}) - $signed({r_a[31], r_a});
    assign w_frac = $signed({1'b0, r_r[15:0]});
    assign w_prod = w_diff * w_frac;

    kps_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pal_we && !w_pal_bad),
        .i_waddr (PAL_AW'(r_waddr)),
        .i_wdata (r_wval),
        .i_raddr (w_pal_raddr),
        .o_rdata (w_pal_rdata)
    );

    kps_ram #(.WIDTH(CLIP_EW), .DEPTH(CLIP_SLOTS)) u_clip_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clip_we && !w_clip_bad),
        .i_waddr (CLIP_AW'(r_slot)),
        .i_wdata ({r_key, r_cstart, r_clen}),
        .i_raddr (w_clip_raddr),
        .o_rdata (w_clip_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bones   <= 9'd1;
            r_clips   <= 5'd1;
            r_o_valid <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_BONES) r_bones <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_CLIPS) r_clips <= i_cfg_data[4:0];
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= DIV_CW'(DIV_STEPS);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_waddr  <= i_word_address;
            r_wval   <= i_word_value;
            r_slot   <= i_clip_slot;
            r_key    <= i_clip_key;
            r_cstart <= i_clip_start;
            r_clen   <= i_clip_length;
            r_time   <= i_time_in_frames;
            r_elem   <= i_element;
            r_r      <= '0;
            r_val    <= '0;
            r_fault  <= 1'b0;
            r_found  <= 1'b0;
            r_idx    <= '0;
        end
        if (i_cmd.pal_we && w_pal_bad) r_fault <= 1'b1;
        if (i_cmd.clip_we && w_clip_bad) r_fault <= 1'b1;
        if (i_cmd.set_fault) r_fault <= 1'b1;
        if (i_cmd.chk_clip) begin
            r_start <= w_clip_rdata[31:16];
            r_len   <= w_clip_rdata[15:0];
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_dvd <= r_time[31] ? (~r_time + 32'd1) : r_time;
        end
        if (i_cmd.div_step) begin
            r_rem <= (w_rem_sh >= {1'b0, w_span}) ? 32'(w_rem_sh - {1'b0, w_span})
                     : w_rem_sh[31:0];
            r_dvd <= {r_dvd[30:0], 1'b0};
        end
        if (i_cmd.div_fix) begin
            r_r <= (r_time[31] && r_rem != 32'd0) ? (w_span - r_rem) : r_rem;
        end
        if (i_cmd.addr_a) r_pa <= w_addr;
        if (i_cmd.addr_b) r_pb <= w_addr;
        if (i_cmd.cap_a) r_a <= w_pal_rdata;
        if (i_cmd.mul) r_prod <= w_prod;
        if (i_cmd.blend) r_val <= r_a + r_prod[47:16];
        if (i_cmd.lk_hit) r_found <= 1'b1;
        if (i_cmd.lk_next) r_idx <= r_idx + 1'b1;
        if (i_cmd.out_load) begin
            r_o_val   <= r_val;
            r_o_fault <= r_fault;
            r_o_found <= r_found;
            r_o_slot  <= r_found ? 4'(r_idx) : 4'd0;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.action     = r_action;
        o_sts.elem_bad   = 13'(r_elem) >= w_n;
        o_sts.short_clip = r_len <= 16'd1;
        o_sts.div_last   = r_div_cnt == DIV_CW'(1);
        o_sts.addr_fault = (32'(r_pa) >= 32'(PALETTE_DEPTH))
                           || ((r_len > 16'd1) && (32'(r_pb) >= 32'(PALETTE_DEPTH)));
        o_sts.lk_end     = (32'(r_idx) >= 32'(r_clips)) || (32'(r_idx) >= 32'(CLIP_SLOTS));
        o_sts.lk_match   = w_clip_rdata[63:32] == r_key;
        o_sts.out_free   = !r_o_valid || i_ready;
    end

    assign o_valid        = r_o_valid;
    assign o_sample_value = r_o_val;
    assign o_fault        = r_o_fault;
    assign o_found        = r_o_found;
    assign o_found_slot   = r_o_slot;

`ifndef NO_ASSERTIONS
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_fault |=> o_sample_value == 32'd0)
        else $error("faulted result carries a nonzero value");
    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_found |=> !o_fault && o_sample_value == 32'd0)
        else $error("lookup hit carries fault or value");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_div_cnt != '0)
        else $error("divider stepped past its last step");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step) && !i_cmd.div_step && r_len != 16'd0 |-> r_rem < w_span)
        else $error("remainder not below the clip span");
`endif

endmodule

FILE: design/keyframe_palette_sampler_unit.sv
// Top level of the keyframe palette sampler.
// Depends on kps_pkg, kps_ctrl and kps_dp.
//
//   channel  | handshake          | contents
//   input    | i_valid / o_ready  | action, palette word, clip entry, sample request
//   output   | o_valid / i_ready  | sample value, fault, found, found slot
//   config   | i_cfg_we           | index 0 bones in use, index 1 clips in use
//
// A write goes straight to the result; an element fault ends a sample, and a short clip skips the division.
// A full sample runs the 32-step remainder unit and then two palette reads.
// A lookup searches the clip slots in turn through the clip memory port.
// Synchronous reset clears the state machine, config, output valid and divider count only.
// A finished result waits in the output register while the next transfer is accepted.
module keyframe_palette_sampler_unit
    import kps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [15:0]        i_word_address,
    input  logic signed [31:0] i_word_value,
    input  logic [3:0]         i_clip_slot,
    input  logic [31:0]        i_clip_key,
    input  logic [15:0]        i_clip_start,
    input  logic [15:0]        i_clip_length,
    input  logic signed [31:0] i_time_in_frames,
    input  logic [11:0]        i_element,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_sample_value,
    output logic               o_fault,
    output logic               o_found,
    output logic [3:0]         o_found_slot,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [8:0]         i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    kps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    kps_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_word_address   (i_word_address),
        .i_word_value     (i_word_value),
        .i_clip_slot      (i_clip_slot),
        .i_clip_key       (i_clip_key),
        .i_clip_start     (i_clip_start),
        .i_clip_length    (i_clip_length),
        .i_time_in_frames (i_time_in_frames),
        .i_element        (i_element),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sample_value   (o_sample_value),
        .o_fault          (o_fault),
        .o_found          (o_found),
        .o_found_slot     (o_found_slot)
    );

endmodule
